[src/rpd_pkg.sv]
// Shared constants, field widths and sequencer states of the random permutation drawer.
package rpd_pkg;

  localparam int POOL_SIZE_DEF = 1024;
  localparam int SIZE_W        = 11;
  localparam int SIZE_RESET    = 64;
  localparam int RAND_W        = 31;
  localparam int VALUE_W       = 10;
  localparam int POS_W         = 10;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 24;
  localparam int OUT_PAD_W     = OUT_TDATA_W - VALUE_W - POS_W - 1;
  localparam int IN_PAD_W      = IN_TDATA_W - RAND_W;
  localparam int STEP_W        = $clog2(RAND_W + 1);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_DIV,
    S_READ,
    S_EMIT,
    S_SHRD,
    S_SHWR
  } state_t;

endpackage

[src/rpd_divider.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module rpd_divider
  import rpd_pkg::*;
#(
  parameter int CW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [CW-1:0]     remainder
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RAND_W-1:0] dvd;
  logic [CW-1:0]     dvs;
  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     rem_next;
  logic [CW:0]       trial;

  // The partial remainder stays below the divisor, so one extra bit holds the trial value.
  always_comb begin
    trial = {rem_r, dvd[RAND_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = CW'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(RAND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dvs   <= divisor;
      rem_r <= '0;
      step  <= '0;
    end else if (busy) begin
      dvd   <= dvd << 1;
      rem_r <= rem_next;
      step  <= step + STEP_W'(1);
    end
  end

  assign remainder = rem_r;

endmodule

[src/rpd_pool.sv]
// Pool memory: one write port and one registered read port.
module rpd_pool
  import rpd_pkg::*;
#(
  parameter int DEPTH = POOL_SIZE_DEF,
  parameter int AW    = $clog2(POOL_SIZE_DEF),
  parameter int DW    = $clog2(POOL_SIZE_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/random_permutation_drawer.sv]
// Random permutation drawer: strike-out shuffle of 0..n-1 driven by random words.
//
// Input words arrive on s_tvalid/s_tready: s_tuser is the kind (0 starts a new
// permutation, 1 draws the next element), s_tdata carries the random word.
// Each draw that finds entries left in the pool gives one result word on
// m_tvalid/m_tready; m_tlast marks the draw that completes the permutation.
// The length n is written on the cfg port and is sampled by a start word.
//
// A start word refills the pool with the identity sequence, one entry a cycle,
// and the block is busy until the fill ends. A draw runs through the bit-serial
// remainder unit (one step per dividend bit, then done), a pool read and the
// load of the result register, after which its result word is valid. Then each
// pool entry above the drawn one moves down by a read and a write, and the
// sequencer returns to idle. Draws after completion are accepted and dropped.
// The result register holds its word while m_tready is low; the next draw can
// run meanwhile and waits only when its own result is ready. After reset the
// length is 64 and the pool is refilled before s_tready rises. cfg_ready is
// always high.
module random_permutation_drawer
  import rpd_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // random_value, zero pad
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // drawn_value, position, check_ok, zero pad
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SIZE_W-1:0]      cfg_data
);

  localparam int CW      = $clog2(POOL_SIZE + 1);
  localparam int IW      = $clog2(POOL_SIZE);
  localparam int SW      = 2 * CW;
  localparam int RESET_N = (SIZE_RESET > POOL_SIZE) ? POOL_SIZE : SIZE_RESET;

  state_t state, state_next;

  logic [SIZE_W-1:0] size_in_use;
  logic [CW-1:0]     size_clamped;
  logic [CW-1:0]     active_n;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rem_cnt;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     sum_next;
  logic [SW-1:0]     expected;
  logic [IW-1:0]     fill_cnt;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     idx_plus;
  logic              shift_more;
  logic              is_last;
  logic              out_free;

  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_rem;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     rd_data;

  logic [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]   out_pos;
  logic               out_check;

  rpd_divider #(
    .CW (CW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (s_tdata[RAND_W-1:0]),
    .divisor   (active_n - count),
    .done      (div_done),
    .remainder (div_rem)
  );

  rpd_pool #(
    .DEPTH (POOL_SIZE),
    .AW    (IW),
    .DW    (IW)
  ) u_pool (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (32'(size_in_use) > 32'(POOL_SIZE)) begin
      size_clamped = CW'(POOL_SIZE);
    end else if (size_in_use == '0) begin
      size_clamped = CW'(1);
    end else begin
      size_clamped = CW'(size_in_use);
    end
  end

  assign idx_plus   = CW'(idx) + CW'(1);
  assign shift_more = idx_plus < rem_cnt;
  assign is_last    = (count == active_n - CW'(1));
  assign sum_next   = sum + SW'(rd_data);
  assign out_free   = !m_tvalid || m_tready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = idx;
    unique case (state)
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_cnt;
        wr_data = fill_cnt;
        if (fill_cnt == IW'(active_n - CW'(1))) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == KIND_START) begin
            state_next = S_FILL;
          end else if (count < active_n) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_SHRD;
        end
      end
      S_SHRD: begin
        if (shift_more) begin
          rd_en      = 1'b1;
          rd_addr    = IW'(idx_plus);
          state_next = S_SHWR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SHWR: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = rd_data;
        state_next = S_SHRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_W'(SIZE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      size_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_n <= CW'(RESET_N);
      count    <= '0;
      sum      <= '0;
      fill_cnt <= '0;
    end else begin
      case (state)
        S_FILL: begin
          fill_cnt <= fill_cnt + IW'(1);
        end
        S_IDLE: begin
          if (s_tvalid && s_tuser == KIND_START) begin
            active_n <= size_clamped;
            count    <= '0;
            sum      <= '0;
            fill_cnt <= '0;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            sum   <= sum_next;
            count <= count + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and pointer registers; the sequencer decides when they are meaningful.
  always_ff @(posedge clk) begin
    if (state == S_FILL) begin
      expected <= (SW'(active_n) * SW'(active_n - CW'(1))) >> 1;
    end
    if (state == S_IDLE && s_tvalid) begin
      rem_cnt <= active_n - count;
    end
    if (state == S_DIV && div_done) begin
      idx <= IW'(div_rem);
    end
    if (state == S_SHWR) begin
      idx <= IW'(idx_plus);
    end
    if (state == S_EMIT && out_free) begin
      out_value <= VALUE_W'(rd_data);
      out_pos   <= POS_W'(count);
      m_tlast   <= is_last;
      out_check <= is_last && (sum_next == expected);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {OUT_PAD_W'(0), out_check, out_pos, out_value};

  // A complete permutation always adds up to the expected total.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_check)
    else $error("last draw reports a failed sum check");

  assert property (@(posedge clk) disable iff (rst)
    count <= active_n)
    else $error("draw count exceeds permutation length");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_rem < rem_cnt)
    else $error("remainder not below remaining pool count");

  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CW'(wr_addr) < active_n)
    else $error("pool write outside the active permutation");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the random permutation drawer with its own shuffle predictor.
module testbench
  import rpd_pkg::*;
;

  localparam int          HOLD_OFF     = 2 * POOL_SIZE_DEF + 64;
  localparam int unsigned RAND_LIMIT   = 32'h7FFF_FFFF;
  localparam int unsigned RANDOM_WORDS = 1500;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               last;
    logic               ok;
  } draw_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_LONG_STALL} rx_mode_t;

  typedef struct packed {
    row_kind_t         what;
    logic [SIZE_W-1:0] len;
    logic              kind;
    logic [RAND_W-1:0] rnd;
    chk_t              chk;
    draw_t             given;
  } row_t;

  localparam draw_t             NO_DRAW  = '0;
  localparam logic [RAND_W-1:0] RND_ZERO = '0;
  localparam logic [RAND_W-1:0] RND_FULL = '1;
  localparam logic [RAND_W-1:0] RND_ALT0 = 31'h5555_5555;
  localparam logic [RAND_W-1:0] RND_ALT1 = 31'h2AAA_AAAA;

  // Expected words are typed in where they are plain to see; the rest come from the predictor.
  localparam row_t DIRECTED_ROWS [30] = '{
    '{ROW_WORD, 11'd0,    KIND_DRAW,  31'd63,   CHK_GIVEN, '{10'd63,   10'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ALT1, CHK_MODEL, NO_DRAW},
    '{ROW_CFG,  11'd1,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_FULL, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ZERO, CHK_GIVEN, '{10'd0,    10'd0, 1'b1, 1'b1}},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_FULL, CHK_NONE,  NO_DRAW},
    '{ROW_CFG,  11'd0,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_FULL, CHK_GIVEN, '{10'd0,    10'd0, 1'b1, 1'b1}},
    '{ROW_CFG,  11'd2,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_FULL, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_FULL, CHK_GIVEN, '{10'd1,    10'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ZERO, CHK_GIVEN, '{10'd0,    10'd1, 1'b1, 1'b1}},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_CFG,  11'd2047, KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_ALT0, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_FULL, CHK_GIVEN, '{10'd1023, 10'd0, 1'b0, 1'b0}},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ZERO, CHK_GIVEN, '{10'd0,    10'd1, 1'b0, 1'b0}},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ALT0, CHK_MODEL, NO_DRAW},
    '{ROW_CFG,  11'd3,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ALT1, CHK_MODEL, NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_FULL, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ALT0, CHK_MODEL, NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_FULL, CHK_MODEL, NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_ZERO, CHK_MODEL, NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  RND_FULL, CHK_NONE,  NO_DRAW},
    '{ROW_CFG,  11'd1024, KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_START, RND_ZERO, CHK_NONE,  NO_DRAW},
    '{ROW_WORD, 11'd0,    KIND_DRAW,  31'd1023, CHK_GIVEN, '{10'd1023, 10'd0, 1'b0, 1'b0}}
  };

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // random_value, zero pad
  logic                   s_tuser   = 1'b0; // kind
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // drawn_value, position, check_ok, zero pad
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SIZE_W-1:0]      cfg_data  = '0;

  random_permutation_drawer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shuffle predictor state.
  logic [VALUE_W-1:0] perm_pool [POOL_SIZE_DEF];
  logic [SIZE_W-1:0]  len_reg;
  int unsigned        perm_len;
  int unsigned        taken_cnt;
  int unsigned        taken_sum;

  draw_t pending_draws [$];
  int    mismatches  = 0;
  int    burst_left  = 0;
  rx_mode_t rx_mode  = RX_OPEN;
  int    rx_hold     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void restart_pool();
    perm_len = (len_reg == '0) ? 1 :
               (len_reg > POOL_SIZE_DEF) ? POOL_SIZE_DEF : int'(len_reg);
    for (int i = 0; i < POOL_SIZE_DEF; i++) perm_pool[i] = VALUE_W'(i);
    taken_cnt = 0;
    taken_sum = 0;
  endfunction

  // Strike-out step: take the entry at rnd mod remaining and close the gap above it.
  function automatic void strike_out_draw(input logic kind, input logic [RAND_W-1:0] rnd,
                                          output bit produced, output draw_t res);
    int unsigned left, pick;
    produced = 1'b0;
    res      = NO_DRAW;
    if (kind == KIND_START) begin
      restart_pool();
      return;
    end
    if (taken_cnt >= perm_len) return;
    left = perm_len - taken_cnt;
    pick = int'(rnd) % left;
    res.value = perm_pool[pick];
    for (int unsigned i = pick; i + 1 < left; i++) perm_pool[i] = perm_pool[i + 1];
    taken_sum += res.value;
    res.pos  = POS_W'(taken_cnt);
    res.last = (taken_cnt + 1 == perm_len);
    res.ok   = res.last && (taken_sum == perm_len * (perm_len - 1) / 2);
    taken_cnt++;
    produced = 1'b1;
  endfunction

  function automatic logic [RAND_W-1:0] next_word(bit near_top);
    int unsigned left, sel, off, mult;
    left = (taken_cnt < perm_len) ? perm_len - taken_cnt : 1;
    sel  = $urandom_range(0, 15);
    if (near_top && sel != 0) sel = 10;
    if (sel == 12) return '0;
    if (sel == 13) return '1;
    if (sel == 10 || sel == 11) begin
      // Landing on one of the top entries keeps the shift short, so long pools stay cheap.
      off  = left - 1 - $urandom_range(0, (left > 4) ? 3 : left - 1);
      mult = $urandom_range(0, (RAND_LIMIT - left) / left);
      return RAND_W'(mult * left + off);
    end
    if (sel >= 6) return RAND_W'($urandom_range(0, 2 * left + 1));
    return RAND_W'($urandom);
  endfunction

  function automatic void log_mismatch(string what, draw_t want, draw_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: expected value %0d pos %0d last %0b ok %0b, ",
                "got value %0d pos %0d last %0b ok %0b"},
               $realtime, what, want.value, want.pos, want.last, want.ok,
               got.value, got.pos, got.last, got.ok);
  endfunction

  task automatic send_word(input logic kind, input logic [RAND_W-1:0] rnd, input chk_t chk,
                           input draw_t given, output bit counted);
    draw_t res;
    bit    produced;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{IN_PAD_W{1'b0}}, rnd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    strike_out_draw(kind, rnd, produced, res);
    if (chk == CHK_GIVEN) pending_draws.push_back(given);
    else if (chk == CHK_MODEL && produced) pending_draws.push_back(res);
    counted = produced || (kind == KIND_START);
    burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4))
        @(posedge clk);
    end
  endtask

  // Stop sending until every expected word is back and the block has surely gone quiet.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_length(input logic [SIZE_W-1:0] len);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    len_reg = len;
  endtask

  // The receiver switches between free flow, light and heavy random stalls, and long stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_hold = $urandom_range(20, 400);
      end
      rx_hold--;
      case (rx_mode)
        RX_OPEN:  m_tready <= 1'b1;
        RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
        default:  m_tready <= (rx_hold % 40 < 8);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    draw_t got;
    got.value = m_tdata[VALUE_W-1:0];
    got.pos   = m_tdata[VALUE_W +: POS_W];
    got.ok    = m_tdata[VALUE_W + POS_W];
    got.last  = m_tlast;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_draws.size() == 0) log_mismatch("word with nothing expected", NO_DRAW, got);
      else if (got !== pending_draws[0]) log_mismatch("word differs", pending_draws.pop_front(), got);
      else void'(pending_draws.pop_front());
    end
  end

  initial begin : stimulus
    int unsigned       words_done, draws, roll, phase;
    bit                counted, big;
    logic [SIZE_W-1:0] new_len;
    len_reg = SIZE_W'(SIZE_RESET);
    restart_pool();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].what == ROW_CFG) write_length(DIRECTED_ROWS[r].len);
      else send_word(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].rnd, DIRECTED_ROWS[r].chk,
                     DIRECTED_ROWS[r].given, counted);
    end

    // Mostly complete permutations of short length, one full-size one, and some broken runs.
    words_done = 0;
    phase      = 0;
    while (words_done < RANDOM_WORDS) begin
      big = (phase == 2);
      roll = $urandom_range(0, 19);
      if (big) new_len = $urandom_range(0, 1) ? SIZE_W'(POOL_SIZE_DEF) : '1;
      else if (roll < 12) new_len = SIZE_W'($urandom_range(1, 16));
      else if (roll < 17) new_len = SIZE_W'($urandom_range(17, 100));
      else if (roll == 17) new_len = '0;
      else if (roll == 18) new_len = SIZE_W'($urandom_range(101, 300));
      else new_len = SIZE_W'($urandom_range(301, 2047));
      if (big || $urandom_range(0, 5) != 0) write_length(new_len);
      send_word(KIND_START, next_word(1'b0), CHK_MODEL, NO_DRAW, counted);
      words_done += counted;
      if (perm_len > 300 && !big) draws = $urandom_range(1, 6);
      else if ($urandom_range(0, 5) == 0) draws = $urandom_range(0, perm_len);
      else draws = perm_len + $urandom_range(0, 2);
      for (int unsigned d = 0; d < draws; d++) begin
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
          send_word(KIND_START, next_word(1'b0), CHK_MODEL, NO_DRAW, counted);
          words_done += counted;
        end else if (roll == 1 && !big) begin
          // A new length written mid-permutation must wait for the next start word.
          write_length(SIZE_W'($urandom_range(0, 2047)));
        end else if (roll == 2) begin
          settle_block();
        end
        send_word(KIND_DRAW, next_word(big), CHK_MODEL, NO_DRAW, counted);
        words_done += counted;
      end
      phase++;
    end

    settle_block();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[random_permutation_drawer.f]
src/rpd_pkg.sv
src/rpd_divider.sv
src/rpd_pool.sv
src/random_permutation_drawer.sv
tb/testbench.sv
